// ----- rtl/core/rfd_pkg.sv -----
// Shared types and codes for the request queue with delete.
// Holds the action and status codes and the packed entry layout.
// No dependencies.
package rfd_pkg;

  typedef enum logic [2:0] {
    ACT_PUSH_NEW      = 3'd0,
    ACT_PUSH_DISPATCH = 3'd1,
    ACT_POP_FRONT     = 3'd2,
    ACT_REMOVE_VALUE  = 3'd3,
    ACT_REMOVE_INDEX  = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_NONE = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  localparam int VALUE_W   = 31;
  localparam int TIME_W    = 48;
  localparam int HANDLER_W = 8;
  localparam int OCC_W     = 7;

  typedef struct packed {
    logic [VALUE_W-1:0]   value;
    logic [TIME_W-1:0]    arrival;
    logic [TIME_W-1:0]    delay;
    logic [HANDLER_W-1:0] handler;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

// ----- rtl/core/request_fifo_with_delete_unit.sv -----
// Ordered request queue with delete; uses rfd_pkg and rfd_ram.
// A push writes the tail slot in the transfer cycle, then passes through S_RESULT.
// A removal walks the queue through the single RAM read port: it scans entries
// up to the target, then moves each entry behind it one slot toward the head.
// Throughput: one item at a time; input is ready only when the sequencer idles.
// Reset: synchronous active-low rst_n empties the queue; RAM content is not cleared.
module request_fifo_with_delete_unit #(
  parameter int DEPTH = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  // in_tdata, from bit 0 up: action[3], item_value[31], arrival_ts[48],
  // now_time[48], handler_id[8], position[6]
  input  logic [143:0] in_tdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  // out_tdata, from bit 0 up: status[2], out_value[31], out_arrival[48],
  // out_delay[48], out_handler[8], occupancy[7]
  output logic [143:0] out_tdata,
  output logic         out_tvalid,
  input  logic         out_tready
);

  // Count width holds DEPTH itself; address width indexes the RAM.
  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW = (CW > 6) ? CW : 6;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_SHIFT  = 4'b0100,
    S_RESULT = 4'b1000
  } state_t;

  // Input field unpack
  logic [2:0]                    in_action;
  logic [rfd_pkg::VALUE_W-1:0]   in_item_value;
  logic [rfd_pkg::TIME_W-1:0]    in_arrival_ts;
  logic [rfd_pkg::TIME_W-1:0]    in_now_time;
  logic [rfd_pkg::HANDLER_W-1:0] in_handler_id;
  logic [5:0]                    in_position;

  assign in_action     = in_tdata[2:0];
  assign in_item_value = in_tdata[33:3];
  assign in_arrival_ts = in_tdata[81:34];
  assign in_now_time   = in_tdata[129:82];
  assign in_handler_id = in_tdata[137:130];
  assign in_position   = in_tdata[143:138];

  // Sequencer state
  state_t                      state_r, state_nxt;
  logic [CW-1:0]               cnt_r, cnt_nxt;       // entries held
  logic [CW-1:0]               iss_r, iss_nxt;       // next RAM read address
  logic                        pend_r, pend_nxt;     // read data arrives this cycle
  logic [AW-1:0]               pidx_r, pidx_nxt;     // address of that read
  logic                        by_idx_r, by_idx_nxt; // match on position, not value
  logic [rfd_pkg::VALUE_W-1:0] key_r, key_nxt;

  // Result staging and output register
  rfd_pkg::status_t res_status_r, res_status_nxt;
  rfd_pkg::entry_t  res_ent_r, res_ent_nxt;
  logic             out_vld_r, out_vld_nxt;
  logic [143:0]     out_data_r, out_data_nxt;

  // RAM port signals
  logic                         wr_en;
  logic [AW-1:0]                wr_addr;
  logic [rfd_pkg::ENTRY_W-1:0]  wr_data;
  logic                         rd_en;
  logic [rfd_pkg::ENTRY_W-1:0]  rd_data;
  rfd_pkg::entry_t              rd_ent;
  rfd_pkg::entry_t              push_ent;

  logic in_xfer;
  logic hit;
  logic out_free;

  // Occupancy reports the low bits of the count.
  function automatic logic [rfd_pkg::OCC_W-1:0] OCC_BITS(input logic [CW-1:0] c);
    return rfd_pkg::OCC_W'(c);
  endfunction

  rfd_ram #(
    .WIDTH (rfd_pkg::ENTRY_W),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (iss_r[AW-1:0]),
    .rd_data (rd_data)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign in_xfer    = in_tvalid && in_tready;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_free   = !out_vld_r || out_tready;

  assign rd_ent = rfd_pkg::entry_t'(rd_data);

  // Issue one read per cycle while walking, as long as addresses stay inside the queue.
  assign rd_en = ((state_r == S_SCAN) || (state_r == S_SHIFT)) && (iss_r < cnt_r);

  // A returning read is the target when matching by position or by equal value.
  assign hit = pend_r && (by_idx_r || (rd_ent.value == key_r));

  // Entry built for a push: a dispatched push stores the wait time mod 2^48.
  always_comb begin
    push_ent.value   = in_item_value;
    push_ent.arrival = in_arrival_ts;
    if (in_action == rfd_pkg::ACT_PUSH_DISPATCH) begin
      push_ent.delay   = in_now_time - in_arrival_ts;
      push_ent.handler = in_handler_id;
    end else begin
      push_ent.delay   = '0;
      push_ent.handler = '0;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    iss_nxt        = iss_r;
    pend_nxt       = 1'b0;
    pidx_nxt       = pidx_r;
    by_idx_nxt     = by_idx_r;
    key_nxt        = key_r;
    res_status_nxt = res_status_r;
    res_ent_nxt    = res_ent_r;
    out_vld_nxt    = out_vld_r && !out_tready;
    out_data_nxt   = out_data_r;
    wr_en          = 1'b0;
    wr_addr        = cnt_r[AW-1:0];
    wr_data        = push_ent;

    // Track the read in flight for the compare or copy in the next cycle.
    if (rd_en) begin
      iss_nxt  = iss_r + 1'b1;
      pend_nxt = 1'b1;
      pidx_nxt = iss_r[AW-1:0];
    end

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          res_ent_nxt = '0;
          case (rfd_pkg::action_t'(in_action))
            rfd_pkg::ACT_PUSH_NEW, rfd_pkg::ACT_PUSH_DISPATCH: begin
              if (cnt_r >= CW'(DEPTH)) begin
                res_status_nxt = rfd_pkg::ST_FULL;
              end else begin
                // Append at the tail in the transfer cycle.
                wr_en          = 1'b1;
                cnt_nxt        = cnt_r + 1'b1;
                res_status_nxt = rfd_pkg::ST_OK;
              end
              state_nxt = S_RESULT;
            end
            rfd_pkg::ACT_POP_FRONT: begin
              by_idx_nxt = 1'b1;
              iss_nxt    = '0;
              state_nxt  = S_SCAN;
            end
            rfd_pkg::ACT_REMOVE_VALUE: begin
              by_idx_nxt = 1'b0;
              key_nxt    = in_item_value;
              iss_nxt    = '0;
              state_nxt  = S_SCAN;
            end
            rfd_pkg::ACT_REMOVE_INDEX: begin
              if (PW'(in_position) >= PW'(cnt_r)) begin
                res_status_nxt = rfd_pkg::ST_NONE;
                state_nxt      = S_RESULT;
              end else begin
                by_idx_nxt = 1'b1;
                iss_nxt    = CW'(in_position);
                state_nxt  = S_SCAN;
              end
            end
            default: begin
              res_status_nxt = rfd_pkg::ST_NONE;
              state_nxt      = S_RESULT;
            end
          endcase
        end
      end

      S_SCAN: begin
        if (hit) begin
          // Capture the removed entry, then close the gap behind it.
          res_status_nxt = rfd_pkg::ST_OK;
          res_ent_nxt    = rd_ent;
          iss_nxt        = CW'(pidx_r) + 1'b1;
          pend_nxt       = 1'b0;
          state_nxt      = S_SHIFT;
        end else if (!pend_r && !rd_en) begin
          res_status_nxt = rfd_pkg::ST_NONE;
          res_ent_nxt    = '0;
          state_nxt      = S_RESULT;
        end
      end

      S_SHIFT: begin
        // Move each entry one slot toward the head.
        if (pend_r) begin
          wr_en   = 1'b1;
          wr_addr = pidx_r - 1'b1;
          wr_data = rd_ent;
        end else if (!rd_en) begin
          cnt_nxt   = cnt_r - 1'b1;
          state_nxt = S_RESULT;
        end
      end

      S_RESULT: begin
        // Hold until the output register is free, then hand the result over.
        if (out_free) begin
          out_vld_nxt  = 1'b1;
          out_data_nxt = {OCC_BITS(cnt_r), res_ent_r.handler, res_ent_r.delay,
                          res_ent_r.arrival, res_ent_r.value, res_status_r};
          state_nxt    = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cnt_r     <= '0;
      pend_r    <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      pend_r    <= pend_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    iss_r        <= iss_nxt;
    pidx_r       <= pidx_nxt;
    by_idx_r     <= by_idx_nxt;
    key_r        <= key_nxt;
    res_status_r <= res_status_nxt;
    res_ent_r    <= res_ent_nxt;
    out_data_r   <= out_data_nxt;
  end

endmodule

// ----- rtl/core/rfd_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Parameters set width and depth. No dependencies.
module rfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
